// File: rtl/fab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fab_pkg
// Shared types and constants of the fit-policy block allocator: field widths,
// register map, opcodes, fit policies, controller states.
// ----------------------------------------------------------------------------
package fab_pkg;

  localparam int OP_W     = 1;
  localparam int SLOT_W   = 6;
  localparam int AMOUNT_W = 16;
  localparam int REMAIN_W = 16;
  localparam int POLICY_W = 2;
  localparam int BCOUNT_W = 7;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic REG_FIT_POLICY  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b1;

  localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 7'd64;

  typedef enum logic [POLICY_W-1:0] {
    POLICY_LAST  = 2'd0,
    POLICY_BEST  = 2'd1,
    POLICY_WORST = 2'd2,
    POLICY_RSVD  = 2'd3
  } policy_t;

  typedef struct packed {
    policy_t              policy;
    logic [BCOUNT_W-1:0]  block_count;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WB
  } state_t;

endpackage

// File: rtl/fab_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fab_item_if
// Input channel: one word is a load or an allocate request.
// ----------------------------------------------------------------------------
interface fab_item_if;
  logic                          valid;
  logic                          ready;
  logic [fab_pkg::OP_W-1:0]      op;
  logic [fab_pkg::SLOT_W-1:0]    slot;
  logic [fab_pkg::AMOUNT_W-1:0]  amount;

  modport source (output valid, op, slot, amount, input ready);
  modport sink   (input valid, op, slot, amount, output ready);
endinterface

// File: rtl/fab_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fab_result_if
// Output channel: one word reports the outcome of an allocate request.
// ----------------------------------------------------------------------------
interface fab_result_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [fab_pkg::SLOT_W-1:0]    chosen_slot;
  logic [fab_pkg::REMAIN_W-1:0]  remaining;

  modport source (output valid, found, chosen_slot, remaining, input ready);
  modport sink   (input valid, found, chosen_slot, remaining, output ready);
endinterface

// File: rtl/fab_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fab_regs
// APB register file holding the fit policy and the active block count.
// ----------------------------------------------------------------------------
module fab_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fab_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [fab_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [fab_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output fab_pkg::cfg_t                     cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.policy      <= fab_pkg::POLICY_BEST;
      cfg.block_count <= fab_pkg::BCOUNT_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        fab_pkg::REG_FIT_POLICY:
          cfg.policy <= fab_pkg::policy_t'(pwdata[fab_pkg::POLICY_W-1:0]);
        fab_pkg::REG_BLOCK_COUNT:
          cfg.block_count <= pwdata[fab_pkg::BCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      fab_pkg::REG_FIT_POLICY:
        prdata = fab_pkg::APB_DATA_W'(cfg.policy);
      fab_pkg::REG_BLOCK_COUNT:
        prdata = fab_pkg::APB_DATA_W'(cfg.block_count);
      default:
        prdata = '0;
    endcase
  end

endmodule

// File: rtl/fab_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fab_mem
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module fab_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  addr,
  input  logic [WIDTH-1:0]          wdata,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: rtl/fab_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fab_engine
// Controller: clears the table after reset, writes loads, scans the table
// one slot per cycle for an allocate, writes back the chosen slot and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module fab_engine #(
  parameter int MAX_BLOCKS = 64,
  parameter int SIZE_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fab_pkg::cfg_t                  cfg,
  fab_item_if.sink                       items,
  fab_result_if.source                   results,
  output logic                           mem_en,
  output logic                           mem_we,
  output logic [$clog2(MAX_BLOCKS)-1:0]  mem_addr,
  output logic [SIZE_BITS-1:0]           mem_wdata,
  input  logic [SIZE_BITS-1:0]           mem_rdata
);

  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int LIM_W   = (CNT_W > fab_pkg::BCOUNT_W) ? CNT_W : fab_pkg::BCOUNT_W;
  localparam int CMP_W   = (SIZE_BITS > fab_pkg::AMOUNT_W) ? SIZE_BITS : fab_pkg::AMOUNT_W;
  localparam int SCMP_W  = (IDX_W + 1 > fab_pkg::SLOT_W) ? IDX_W + 1 : fab_pkg::SLOT_W;
  localparam int PICK_W  = (IDX_W > fab_pkg::SLOT_W) ? IDX_W : fab_pkg::SLOT_W;
  localparam int REM_X_W = (SIZE_BITS > fab_pkg::REMAIN_W) ? SIZE_BITS : fab_pkg::REMAIN_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);

  fab_pkg::state_t state, state_next;

  logic [IDX_W-1:0]             clr_idx, clr_idx_next;
  logic [IDX_W-1:0]             cmp_idx, cmp_idx_next;
  logic [fab_pkg::AMOUNT_W-1:0] req, req_next;
  logic                         have, have_next;
  logic [SIZE_BITS-1:0]         keep, keep_next;
  logic [IDX_W-1:0]             pick, pick_next;

  logic                         out_valid;
  logic                         out_found;
  logic [fab_pkg::SLOT_W-1:0]   out_slot;
  logic [fab_pkg::REMAIN_W-1:0] out_remain;
  logic                         push;

  logic [LIM_W-1:0]  bc_ext, lim, lim_dec;
  logic              lim_zero;
  logic [IDX_W-1:0]  lim_m1;
  logic [SCMP_W-1:0] slot_ext;
  logic              slot_ok;
  logic [CMP_W-1:0]  amt_ext, req_ext, v_ext;
  logic              fits, take;
  logic [SIZE_BITS-1:0] req_trunc, new_size;
  logic [PICK_W-1:0]    pick_ext;
  logic [REM_X_W-1:0]   new_ext;

  assign bc_ext   = LIM_W'(cfg.block_count);
  assign lim      = (bc_ext > LIM_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS) : bc_ext;
  assign lim_zero = (lim == '0);
  assign lim_dec  = lim - LIM_W'(1);
  assign lim_m1   = lim_dec[IDX_W-1:0];

  assign slot_ext = SCMP_W'(items.slot);
  assign slot_ok  = slot_ext < SCMP_W'(MAX_BLOCKS);
  assign amt_ext  = CMP_W'(items.amount);

  assign req_ext   = CMP_W'(req);
  assign req_trunc = req_ext[SIZE_BITS-1:0];
  assign v_ext     = CMP_W'(mem_rdata);
  assign fits      = v_ext >= req_ext;
  assign new_size  = keep - req_trunc;
  assign new_ext   = REM_X_W'(new_size);
  assign pick_ext  = PICK_W'(pick);

  always_comb begin
    case (cfg.policy) inside
      fab_pkg::POLICY_LAST:                       take = fits;
      fab_pkg::POLICY_BEST:                       take = fits && (!have || mem_rdata <= keep);
      fab_pkg::POLICY_WORST, fab_pkg::POLICY_RSVD: take = fits && (!have || mem_rdata >= keep);
      default:                                    take = 1'b0;
    endcase
  end

  always_comb begin
    state_next   = state;
    clr_idx_next = clr_idx;
    cmp_idx_next = cmp_idx;
    req_next     = req;
    have_next    = have;
    keep_next    = keep;
    pick_next    = pick;
    items.ready  = 1'b0;
    push         = 1'b0;
    mem_en       = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = '0;
    mem_wdata    = '0;

    unique case (state)
      fab_pkg::ST_CLEAR: begin
        mem_en       = 1'b1;
        mem_we       = 1'b1;
        mem_addr     = clr_idx;
        clr_idx_next = clr_idx + IDX_W'(1);
        if (clr_idx == LAST_IDX) begin
          state_next = fab_pkg::ST_IDLE;
        end
      end
      fab_pkg::ST_IDLE: begin
        items.ready = 1'b1;
        if (items.valid) begin
          if (items.op == fab_pkg::OP_LOAD) begin
            mem_en    = slot_ok;
            mem_we    = 1'b1;
            mem_addr  = slot_ext[IDX_W-1:0];
            mem_wdata = amt_ext[SIZE_BITS-1:0];
          end else begin
            req_next  = items.amount;
            have_next = 1'b0;
            if (lim_zero) begin
              state_next = fab_pkg::ST_WB;
            end else begin
              mem_en       = 1'b1;
              mem_addr     = '0;
              cmp_idx_next = '0;
              state_next   = fab_pkg::ST_SCAN;
            end
          end
        end
      end
      fab_pkg::ST_SCAN: begin
        if (take) begin
          have_next = 1'b1;
          keep_next = mem_rdata;
          pick_next = cmp_idx;
        end
        if (cmp_idx == lim_m1) begin
          state_next = fab_pkg::ST_WB;
        end else begin
          mem_en       = 1'b1;
          mem_addr     = cmp_idx + IDX_W'(1);
          cmp_idx_next = cmp_idx + IDX_W'(1);
        end
      end
      fab_pkg::ST_WB: begin
        if (!out_valid || results.ready) begin
          push       = 1'b1;
          mem_en     = have;
          mem_we     = 1'b1;
          mem_addr   = pick;
          mem_wdata  = new_size;
          state_next = fab_pkg::ST_IDLE;
        end
      end
      default: state_next = fab_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fab_pkg::ST_CLEAR;
      clr_idx   <= '0;
      have      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      have    <= have_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= cmp_idx_next;
    req     <= req_next;
    keep    <= keep_next;
    pick    <= pick_next;
    if (push) begin
      out_found  <= have;
      out_slot   <= have ? pick_ext[fab_pkg::SLOT_W-1:0] : '0;
      out_remain <= have ? new_ext[fab_pkg::REMAIN_W-1:0] : '0;
    end
  end

  assign results.valid       = out_valid;
  assign results.found       = out_found;
  assign results.chosen_slot = out_slot;
  assign results.remaining   = out_remain;

endmodule

// File: rtl/fit_policy_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Free-block table with last-fit, best-fit and worst-fit allocation.
// ----------------------------------------------------------------------------
// After reset the block clears its table, one slot a cycle, and takes no
// word in that time; register writes are taken as ever. An allocate word
// reads the active slots one a cycle through the single port of the table
// RAM and then writes back the chosen slot (it reads none when block_count
// is zero). The result waits in an output register, and the next word is
// taken while it waits; an allocate that reaches write-back while an earlier
// result still waits holds there until that result is taken.
module fit_policy_block_allocator #(
  parameter int MAX_BLOCKS = 64,
  parameter int SIZE_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fab_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [fab_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [fab_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  fab_item_if.sink                        items,
  fab_result_if.source                    results
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);

  fab_pkg::cfg_t        cfg;
  logic                 mem_en;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_addr;
  logic [SIZE_BITS-1:0] mem_wdata;
  logic [SIZE_BITS-1:0] mem_rdata;

  fab_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fab_mem #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (SIZE_BITS)
  ) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  fab_engine #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .items     (items),
    .results   (results),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

endmodule
